FILE: src/tpme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpme_pkg
// Shared types, sizes and helpers of the two-processor makespan evaluator.
// ----------------------------------------------------------------------------
package tpme_pkg;

  localparam int NTASK    = 64;
  localparam int TASK_W   = 6;
  localparam int SCAN_W   = TASK_W + 1;
  localparam int COST_W   = 16;
  localparam int TIME_W   = 24;
  localparam int EDGE_AW  = 2 * TASK_W;
  localparam int EDGE_W   = COST_W + 1;
  localparam int SCHED_W  = TIME_W + 1;

  typedef enum logic [1:0] {
    FUNC_COST  = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_STEP  = 2'd2,
    FUNC_CLEAR = 2'd3
  } tpme_func_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [TASK_W-1:0] task_id;
    logic [TASK_W-1:0] other_task;
    logic [COST_W-1:0] value;
    logic              processor;
    logic              last;
  } tpme_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] makespan;
    logic              is_last;
  } tpme_out_t;

  typedef struct packed {
    logic              init;
    logic [TIME_W-1:0] init_time;
    logic              issue;
    logic              placed;
    logic              proc;
  } tpme_scan_ctl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] cost_ext(input logic [COST_W-1:0] c);
    return {{(TIME_W - COST_W){1'b0}}, c};
  endfunction

endpackage
`default_nettype wire

FILE: src/tpme_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpme_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/tpme_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpme_scan
// Predecessor scan pipeline: one candidate per cycle, running latest arrival.
// ----------------------------------------------------------------------------
module tpme_scan
  import tpme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpme_scan_ctl_t    ctl,
  input  wire logic [SCHED_W-1:0] sched_rdata,
  input  wire logic [COST_W-1:0] cost_rdata,
  input  wire logic [EDGE_W-1:0] edge_rdata,
  output logic      [TIME_W-1:0] max_time
);

  logic              iss_d_r;
  logic              plc_d_r;
  logic              qa_r;
  logic [TIME_W-1:0] sum1_r;
  logic [COST_W-1:0] ecost_r;
  logic [TIME_W-1:0] max_r;
  logic              qa_nxt;
  logic [TIME_W-1:0] cand;

  assign qa_nxt = iss_d_r && plc_d_r && (sched_rdata[SCHED_W-1] != ctl.proc) &&
                  edge_rdata[EDGE_W-1];
  assign cand   = sat_add(sum1_r, cost_ext(ecost_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_d_r <= 1'b0;
      plc_d_r <= 1'b0;
      qa_r    <= 1'b0;
    end else begin
      iss_d_r <= ctl.issue;
      plc_d_r <= ctl.placed;
      qa_r    <= qa_nxt;
    end
    sum1_r  <= sat_add(sched_rdata[TIME_W-1:0], cost_ext(cost_rdata));
    ecost_r <= edge_rdata[COST_W-1:0];
    priority if (ctl.init) begin
      max_r <= ctl.init_time;
    end else if (qa_r && (cand > max_r)) begin
      max_r <= cand;
    end else begin
      max_r <= max_r;
    end
  end

  assign max_time = max_r;

endmodule
`default_nettype wire

FILE: src/two_processor_makespan_eval_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_processor_makespan_eval_unit
// Makespan of a two-processor task schedule with communication costs.
// ----------------------------------------------------------------------------
// Usage:
//   in_data transfers when start is high and busy is low. func selects a task
//   cost load, an edge load, a schedule step or a clear of all edges.
//   Loads complete at the transfer edge and keep busy low.
//   A schedule step emits one result on out_data, marked by out_strobe for
//   one cycle. The strobe rises after the cost, finish and output states when
//   the step is on the processor of the step before (or is the first step);
//   otherwise the predecessor scan runs first: it walks all 64 possible
//   predecessors through the edge, start and cost memories at one entry per
//   cycle, then drains its pipeline before the cost state.
//   A clear of all edges sweeps the 4096-entry edge memory, one entry per
//   cycle, with busy high until the sweep ends.
//   Reset runs the same sweep before the first transfer and empties the run
//   state. The receiver cannot stall; a result is present for exactly one
//   cycle. A step with last set also gives the makespan and ends the run.
// ----------------------------------------------------------------------------
module two_processor_makespan_eval_unit
  import tpme_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire tpme_in_t  in_data,
  output logic           out_strobe,
  output tpme_out_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_SCAN,
    S_COST,
    S_FIN,
    S_OUT
  } state_t;

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NTASK + 1);

  state_t             state_r;
  logic [EDGE_AW-1:0] clr_cnt_r;
  logic [SCAN_W-1:0]  scan_cnt_r;
  logic [TASK_W-1:0]  tid_r;
  logic               proc_r;
  logic               last_r;
  logic [NTASK-1:0]   valid_r;
  logic [TIME_W-1:0]  pf_r [2];
  logic               prev_vld_r;
  logic               prev_proc_r;
  logic               out_strobe_r;
  tpme_out_t          out_data_r;

  logic               accept;
  logic [TASK_W-1:0]  scan_idx;
  logic [TIME_W-1:0]  max_time;
  logic [TIME_W-1:0]  fin;

  logic               cost_we;
  logic [TASK_W-1:0]  cost_raddr;
  logic [COST_W-1:0]  cost_rdata;
  logic               edge_we;
  logic [EDGE_AW-1:0] edge_waddr;
  logic [EDGE_W-1:0]  edge_wdata;
  logic [EDGE_W-1:0]  edge_rdata;
  logic               sched_we;
  logic [SCHED_W-1:0] sched_rdata;
  tpme_scan_ctl_t     scan_ctl;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign scan_idx = scan_cnt_r[TASK_W-1:0];

  assign cost_we    = accept && (in_data.func == FUNC_COST);
  assign cost_raddr = (state_r == S_SCAN) ? scan_idx : tid_r;

  assign edge_we    = (state_r == S_CLR) || (accept && (in_data.func == FUNC_EDGE));
  assign edge_waddr = (state_r == S_CLR) ? clr_cnt_r : {in_data.other_task, in_data.task_id};
  assign edge_wdata = (state_r == S_CLR) ? '0 : {1'b1, in_data.value};

  assign sched_we   = (state_r == S_FIN);

  assign scan_ctl.init      = accept && (in_data.func == FUNC_STEP);
  assign scan_ctl.init_time = pf_r[in_data.processor];
  assign scan_ctl.issue     = (state_r == S_SCAN) && !scan_cnt_r[SCAN_W-1];
  assign scan_ctl.placed    = valid_r[scan_idx];
  assign scan_ctl.proc      = proc_r;

  assign fin = sat_add(max_time, cost_ext(cost_rdata));

  tpme_ram #(.WIDTH(COST_W), .DEPTH(NTASK)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (in_data.task_id),
    .wdata (in_data.value),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  tpme_ram #(.WIDTH(EDGE_W), .DEPTH(NTASK * NTASK)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr ({scan_idx, tid_r}),
    .rdata (edge_rdata)
  );

  tpme_ram #(.WIDTH(SCHED_W), .DEPTH(NTASK)) u_sched_ram (
    .clk   (clk),
    .we    (sched_we),
    .waddr (tid_r),
    .wdata ({proc_r, max_time}),
    .raddr (scan_idx),
    .rdata (sched_rdata)
  );

  tpme_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .sched_rdata (sched_rdata),
    .cost_rdata  (cost_rdata),
    .edge_rdata  (edge_rdata),
    .max_time    (max_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      valid_r      <= '0;
      pf_r[0]      <= '0;
      pf_r[1]      <= '0;
      prev_vld_r   <= 1'b0;
      prev_proc_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.func)
              FUNC_COST, FUNC_EDGE: begin
              end
              FUNC_STEP: begin
                tid_r      <= in_data.task_id;
                proc_r     <= in_data.processor;
                last_r     <= in_data.last;
                scan_cnt_r <= '0;
                state_r    <= (prev_vld_r && (prev_proc_r != in_data.processor)) ?
                              S_SCAN : S_COST;
              end
              FUNC_CLEAR: begin
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == SCAN_END) begin
            state_r <= S_COST;
          end
        end
        S_COST: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          pf_r[proc_r]   <= fin;
          valid_r[tid_r] <= 1'b1;
          prev_vld_r     <= 1'b1;
          prev_proc_r    <= proc_r;
          state_r        <= S_OUT;
        end
        S_OUT: begin
          out_strobe_r          <= 1'b1;
          out_data_r.start_time <= max_time;
          out_data_r.is_last    <= last_r;
          if (last_r) begin
            out_data_r.makespan <= (pf_r[0] > pf_r[1]) ? pf_r[0] : pf_r[1];
            valid_r             <= '0;
            pf_r[0]             <= '0;
            pf_r[1]             <= '0;
            prev_vld_r          <= 1'b0;
            prev_proc_r         <= 1'b0;
          end else begin
            out_data_r.makespan <= '0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_last_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.is_last) |->
      (pf_r[0] == '0) && (pf_r[1] == '0) && !prev_vld_r && (valid_r == '0))
    else $error("run state not cleared after last step");

  a_step_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.func == FUNC_STEP)) |=> busy)
    else $error("schedule step did not raise busy");

  a_makespan_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.is_last) |-> (out_data.makespan == '0))
    else $error("makespan nonzero on a non-final result");

  a_fin_after_cost: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> ($past(state_r) == S_COST))
    else $error("finish entered without cost read");

endmodule
`default_nettype wire
